### rtl/ffs_pkg.sv
// ----------------------------------------------------------------------------
// ffs_pkg: shared types and microcode for the flipbook frame sequencer
// Payload structs, request and register codes, datapath operations and the
// read-only control program that the sequencer steps through.
// ----------------------------------------------------------------------------
`default_nettype none

package ffs_pkg;

    localparam int REQ_W      = 3;
    localparam int DELTA_W    = 24;
    localparam int FIDX_W     = 12;
    localparam int OFRM_W     = 12;
    localparam int OTOT_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_FLD_W  = 7;
    localparam int PER_W      = 20;
    localparam int ACC_W      = 32;
    localparam int DIV_N      = ACC_W;
    localparam int STEP_W     = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_PLAY  = 3'd1,
        REQ_PAUSE = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_RESET = 3'd4,
        REQ_SET   = 3'd5
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS      = 3'd0,
        CFG_COLS      = 3'd1,
        CFG_PERIOD    = 3'd2,
        CFG_LOOPING   = 3'd3,
        CFG_AUTO_PLAY = 3'd4
    } cfg_idx_t;

    // datapath operations, one per control word
    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_ACC_ADD  = 3'd1,
        OP_DIV_STEP = 3'd2,
        OP_MUL      = 3'd3,
        OP_END_STOP = 3'd4,
        OP_ADVANCE  = 3'd5,
        OP_CMD      = 3'd6,
        OP_EMIT     = 3'd7
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        CND_NEVER    = 3'd0,
        CND_ALWAYS   = 3'd1,
        CND_NO_TICK  = 3'd2,
        CND_DIV_MORE = 3'd3,
        CND_Q_ZERO   = 3'd4,
        CND_NO_STOP  = 3'd5
    } cnd_t;

    localparam logic [STEP_W-1:0] ST_CHECK = 4'd0;
    localparam logic [STEP_W-1:0] ST_LOAD  = 4'd1;
    localparam logic [STEP_W-1:0] ST_DIV   = 4'd2;
    localparam logic [STEP_W-1:0] ST_QTEST = 4'd3;
    localparam logic [STEP_W-1:0] ST_MUL   = 4'd4;
    localparam logic [STEP_W-1:0] ST_STOP  = 4'd5;
    localparam logic [STEP_W-1:0] ST_ADV   = 4'd6;
    localparam logic [STEP_W-1:0] ST_CMD   = 4'd7;
    localparam logic [STEP_W-1:0] ST_EMIT  = 4'd8;

    typedef struct packed {
        op_t               op;
        cnd_t              cnd;
        logic [STEP_W-1:0] target;
        logic              last;
    } uword_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [DELTA_W-1:0] delta_time;
        logic [FIDX_W-1:0]  frame_index;
    } in_item_t;

    typedef struct packed {
        logic [OFRM_W-1:0] current_frame;
        logic [OTOT_W-1:0] total_frames;
        logic              playing;
        logic              needs_tick;
    } out_item_t;

    typedef struct packed {
        logic [PER_W-1:0] period;
        logic             looping;
        logic             auto_play;
    } cfg_t;

    typedef struct packed {
        logic set_play;
        logic clamp;
    } cfg_evt_t;

    typedef struct packed {
        logic tick_go;
        logic div_more;
        logic q_zero;
        logic no_stop;
    } dp_flags_t;

    typedef struct packed {
        op_t  op;
        logic emit;
        logic busy;
    } seq_ctl_t;

    // control program
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            ST_CHECK: w = '{op: OP_NOP,      cnd: CND_NO_TICK,  target: ST_CMD,   last: 1'b0};
            ST_LOAD:  w = '{op: OP_ACC_ADD,  cnd: CND_NEVER,    target: ST_CHECK, last: 1'b0};
            ST_DIV:   w = '{op: OP_DIV_STEP, cnd: CND_DIV_MORE, target: ST_DIV,   last: 1'b0};
            ST_QTEST: w = '{op: OP_NOP,      cnd: CND_Q_ZERO,   target: ST_EMIT,  last: 1'b0};
            ST_MUL:   w = '{op: OP_MUL,      cnd: CND_NO_STOP,  target: ST_ADV,   last: 1'b0};
            ST_STOP:  w = '{op: OP_END_STOP, cnd: CND_ALWAYS,   target: ST_EMIT,  last: 1'b0};
            ST_ADV:   w = '{op: OP_ADVANCE,  cnd: CND_ALWAYS,   target: ST_EMIT,  last: 1'b0};
            ST_CMD:   w = '{op: OP_CMD,      cnd: CND_NEVER,    target: ST_CHECK, last: 1'b0};
            ST_EMIT:  w = '{op: OP_EMIT,     cnd: CND_NEVER,    target: ST_CHECK, last: 1'b1};
            default:  w = '{op: OP_EMIT,     cnd: CND_NEVER,    target: ST_CHECK, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/flipbook_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// flipbook_frame_sequencer_core: sprite-sheet frame sequencer
// Advances the frame of a rows x columns sprite sheet by elapsed time and
// runs playback commands; one status result per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data   (in_item_t)
//  out     | output    | out_valid/out_stall| out_data  (out_item_t)
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
//  Commands and gated ticks pass from the check step to the command step, then
//  to the result step. An active tick runs the 32-step restoring divider, then the
//  result step if no whole period elapsed, else multiply and advance (or end-stop).
//  Reset clears control, configuration and playback state at once; no clearing pass.
//  A finished result waits in the output register; the next request is taken
//  meanwhile, and its final step holds until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module flipbook_frame_sequencer_core
    import ffs_pkg::*;
#(
    parameter int MAX_ROWS       = 64,
    parameter int MAX_COLS       = 64,
    parameter int TIME_FRAC_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ROW_MAX = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COL_MAX = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int TOT_MAX = ROW_MAX * COL_MAX;
    localparam int FRM_W   = (TOT_MAX > 1) ? $clog2(TOT_MAX) : 1;
    localparam int TOT_W   = $clog2(TOT_MAX + 1);

    cfg_t             cfg;
    cfg_evt_t         evt;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] total_next;
    dp_flags_t        flags;
    seq_ctl_t         ctl;
    logic [FRM_W-1:0] frame;
    logic             play;
    logic             in_acc;

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    assign in_stall = ctl.busy;
    assign in_acc   = in_valid && !in_stall;

    ffs_cfg #(
        .MAX_ROWS       (MAX_ROWS),
        .MAX_COLS       (MAX_COLS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS),
        .TOT_W          (TOT_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (cfg_we),
        .index      (cfg_index),
        .wdata      (cfg_wdata),
        .cfg        (cfg),
        .evt        (evt),
        .total      (total),
        .total_next (total_next)
    );

    ffs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .flags    (flags),
        .out_full (out_valid_reg && out_stall),
        .ctl      (ctl)
    );

    ffs_dp #(
        .FRM_W (FRM_W),
        .TOT_W (TOT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_acc),
        .in_data    (in_data),
        .ctl        (ctl),
        .cfg        (cfg),
        .evt        (evt),
        .total      (total),
        .total_next (total_next),
        .flags      (flags),
        .frame      (frame),
        .play       (play)
    );

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_next.current_frame = OFRM_W'(frame);
            out_next.total_frames  = OTOT_W'(total);
            out_next.playing       = play;
            out_next.needs_tick    = (total > TOT_W'(1));
            out_valid_next         = 1'b1;
        end
        else if (!out_stall)
        begin
            // drop the transaction once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("accepted transaction did not start the sequencer");

    a_done_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> $past(ctl.emit))
        else $error("sequencer went idle without a result");

    a_emit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> out_valid)
        else $error("result step did not load the output register");
`endif

endmodule

`default_nettype wire

### rtl/ffs_cfg.sv
// ----------------------------------------------------------------------------
// ffs_cfg: configuration registers
// Saturates written values, keeps the sheet frame count and flags the state
// side effects of a write (frame clamp, play set).
// ----------------------------------------------------------------------------
`default_nettype none

module ffs_cfg
    import ffs_pkg::*;
#(
    parameter int MAX_ROWS       = 64,
    parameter int MAX_COLS       = 64,
    parameter int TIME_FRAC_BITS = 16,
    parameter int TOT_W          = 13
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  we,
    input  wire logic [CFG_IDX_W-1:0]  index,
    input  wire logic [CFG_DATA_W-1:0] wdata,
    output cfg_t                       cfg,
    output cfg_evt_t                   evt,
    output logic [TOT_W-1:0]           total,
    output logic [TOT_W-1:0]           total_next
);

    localparam int ROW_MAX     = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COL_MAX     = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int RW          = $clog2(ROW_MAX + 1);
    localparam int CW          = $clog2(COL_MAX + 1);
    localparam int PW          = RW + CW;
    localparam int PER_MAX     = (1 << PER_W) - 1;
    localparam int PER_RST_RAW = ((1 << TIME_FRAC_BITS) + 9) / 10;
    localparam int PER_RST     = (PER_RST_RAW > PER_MAX) ? PER_MAX : PER_RST_RAW;

    localparam logic [CFG_FLD_W-1:0] ROW_CAP = CFG_FLD_W'(ROW_MAX);
    localparam logic [CFG_FLD_W-1:0] COL_CAP = CFG_FLD_W'(COL_MAX);
    localparam logic [ACC_W-1:0]     PER_CAP = ACC_W'(10) << TIME_FRAC_BITS;

    logic [RW-1:0]    rows_reg, rows_next;
    logic [CW-1:0]    cols_reg, cols_next;
    logic [PER_W-1:0] period_reg, period_next;
    logic             looping_reg, looping_next;
    logic             auto_reg, auto_next;
    logic [TOT_W-1:0] total_reg;

    logic [CFG_FLD_W-1:0] fld;
    logic [CFG_FLD_W-1:0] row_sat;
    logic [CFG_FLD_W-1:0] col_sat;
    logic [PER_W-1:0]     per_raw;
    logic [PER_W-1:0]     per_sat;
    logic [PW-1:0]        prod;

    always_comb
    begin
        fld     = wdata[CFG_FLD_W-1:0];
        per_raw = wdata[PER_W-1:0];

        if (fld == '0)
            row_sat = CFG_FLD_W'(1);
        else if (fld > ROW_CAP)
            row_sat = ROW_CAP;
        else
            row_sat = fld;

        if (fld == '0)
            col_sat = CFG_FLD_W'(1);
        else if (fld > COL_CAP)
            col_sat = COL_CAP;
        else
            col_sat = fld;

        if (per_raw == '0)
            per_sat = PER_W'(1);
        else if (ACC_W'(per_raw) > PER_CAP)
            per_sat = PER_W'(PER_CAP);
        else
            per_sat = per_raw;

        rows_next    = rows_reg;
        cols_next    = cols_reg;
        period_next  = period_reg;
        looping_next = looping_reg;
        auto_next    = auto_reg;
        if (we)
        begin
            case (index)
                CFG_ROWS:      rows_next    = RW'(row_sat);
                CFG_COLS:      cols_next    = CW'(col_sat);
                CFG_PERIOD:    period_next  = per_sat;
                CFG_LOOPING:   looping_next = wdata[0];
                CFG_AUTO_PLAY: auto_next    = wdata[0];
                default:
                begin
                end
            endcase
        end

        prod       = PW'(rows_next) * PW'(cols_next);
        total_next = TOT_W'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= RW'(1);
            cols_reg    <= CW'(1);
            period_reg  <= PER_W'(PER_RST);
            looping_reg <= 1'b1;
            auto_reg    <= 1'b1;
            total_reg   <= TOT_W'(1);
        end
        else
        begin
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            period_reg  <= period_next;
            looping_reg <= looping_next;
            auto_reg    <= auto_next;
            total_reg   <= total_next;
        end
    end

    always_comb
    begin
        cfg.period    = period_reg;
        cfg.looping   = looping_reg;
        cfg.auto_play = auto_reg;
        evt.clamp     = we && ((index == CFG_ROWS) || (index == CFG_COLS));
        evt.set_play  = we && (index == CFG_AUTO_PLAY) && wdata[0];
        total         = total_reg;
    end

endmodule

`default_nettype wire

### rtl/ffs_seq.sv
// ----------------------------------------------------------------------------
// ffs_seq: microcode sequencer
// Step counter over the control program, conditional jumps on datapath flags,
// and hold on the result step while the output register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module ffs_seq
    import ffs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire dp_flags_t flags,
    input  wire logic      out_full,
    output seq_ctl_t       ctl
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;

    uword_t uw;
    logic   take;
    logic   hold;

    always_comb
    begin
        uw = ucode_rom(step_reg);
        case (uw.cnd)
            CND_NEVER:    take = 1'b0;
            CND_ALWAYS:   take = 1'b1;
            CND_NO_TICK:  take = !flags.tick_go;
            CND_DIV_MORE: take = flags.div_more;
            CND_Q_ZERO:   take = flags.q_zero;
            CND_NO_STOP:  take = flags.no_stop;
            default:      take = 1'b0;
        endcase
        hold = (uw.op == OP_EMIT) && out_full;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = ST_CHECK;
            end
        end
        else if (!hold)
        begin
            if (uw.last)
                busy_next = 1'b0;
            else if (take)
                step_next = uw.target;
            else
                step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= ST_CHECK;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctl.op   = busy_reg ? uw.op : OP_NOP;
        ctl.emit = busy_reg && (uw.op == OP_EMIT) && !out_full;
        ctl.busy = busy_reg;
    end

endmodule

`default_nettype wire

### rtl/ffs_dp.sv
// ----------------------------------------------------------------------------
// ffs_dp: playback datapath
// Frame, accumulator and play state, a one-bit-per-step restoring divider
// that also folds the quotient modulo the frame count, and one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ffs_dp
    import ffs_pkg::*;
#(
    parameter int FRM_W = 12,
    parameter int TOT_W = 13
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire in_item_t         in_data,
    input  wire seq_ctl_t         ctl,
    input  wire cfg_t             cfg,
    input  wire cfg_evt_t         evt,
    input  wire logic [TOT_W-1:0] total,
    input  wire logic [TOT_W-1:0] total_next,
    output dp_flags_t             flags,
    output logic [FRM_W-1:0]      frame,
    output logic                  play
);

    localparam int XW    = FRM_W + 1;
    localparam int WW    = (XW > FIDX_W) ? XW : FIDX_W;
    localparam int CNT_W = $clog2(DIV_N);
    localparam int PRD_W = XW + PER_W;

    in_item_t          item_reg, item_next;
    logic [FRM_W-1:0]  frame_reg, frame_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              play_reg, play_next;
    logic [ACC_W-1:0]  dvd_reg, dvd_next;
    logic [PER_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  q_reg, q_next;
    logic [FRM_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  prod_reg, prod_next;

    logic [XW-1:0]     total_x;
    logic [XW-1:0]     steps;
    logic [PER_W:0]    rsh;
    logic [PER_W:0]    per_x;
    logic              qbit;
    logic [PER_W-1:0]  rem_step;
    logic [XW-1:0]     r2;
    logic [FRM_W-1:0]  r_step;
    logic [PRD_W-1:0]  prod_full;
    logic [XW-1:0]     wrap;
    logic [FRM_W-1:0]  wrap_fix;
    logic [FRM_W-1:0]  last_frame;
    logic [FRM_W-1:0]  set_frame;
    logic [FRM_W-1:0]  clamp_frame;
    logic [ACC_W-1:0]  acc_sum;

    // arithmetic around the divider and the frame counter
    always_comb
    begin
        total_x   = XW'(total);
        steps     = total_x - XW'(frame_reg);

        // one restoring step: shift in the next dividend bit
        rsh       = {rem_reg, dvd_reg[ACC_W-1]};
        per_x     = {1'b0, cfg.period};
        qbit      = (rsh >= per_x);
        rem_step  = qbit ? PER_W'(rsh - per_x) : rsh[PER_W-1:0];

        // quotient kept modulo the frame count alongside
        r2        = {r_reg, qbit};
        r_step    = (r2 >= total_x) ? FRM_W'(r2 - total_x) : r2[FRM_W-1:0];

        prod_full = PRD_W'(steps) * PRD_W'(cfg.period);

        wrap      = XW'(frame_reg) + XW'(r_reg);
        wrap_fix  = (wrap >= total_x) ? FRM_W'(wrap - total_x) : wrap[FRM_W-1:0];

        last_frame = FRM_W'(total - TOT_W'(1));
        if (WW'(item_reg.frame_index) >= WW'(total))
            set_frame = last_frame;
        else
            set_frame = FRM_W'(item_reg.frame_index);

        if (XW'(frame_reg) >= XW'(total_next))
            clamp_frame = FRM_W'(total_next - TOT_W'(1));
        else
            clamp_frame = frame_reg;

        acc_sum = acc_reg + ACC_W'(item_reg.delta_time);
    end

    always_comb
    begin
        item_next  = load ? in_data : item_reg;
        frame_next = frame_reg;
        acc_next   = acc_reg;
        play_next  = play_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;

        if (evt.clamp)
            frame_next = clamp_frame;
        if (evt.set_play)
            play_next = 1'b1;

        case (ctl.op)
            OP_ACC_ADD:
            begin
                acc_next = acc_sum;
                dvd_next = acc_sum;
                rem_next = '0;
                q_next   = '0;
                r_next   = '0;
                cnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                dvd_next = {dvd_reg[ACC_W-2:0], 1'b0};
                rem_next = rem_step;
                q_next   = {q_reg[ACC_W-2:0], qbit};
                r_next   = r_step;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_MUL:
            begin
                prod_next = ACC_W'(prod_full);
            end
            OP_END_STOP:
            begin
                // no looping: park on the last frame, keep the leftover time
                acc_next   = acc_reg - prod_reg;
                frame_next = last_frame;
                play_next  = 1'b0;
            end
            OP_ADVANCE:
            begin
                acc_next = ACC_W'(rem_reg);
                if (cfg.looping)
                    frame_next = wrap_fix;
                else
                    frame_next = frame_reg + FRM_W'(q_reg);
            end
            OP_CMD:
            begin
                case (item_reg.req_type)
                    REQ_PLAY:  play_next = 1'b1;
                    REQ_PAUSE: play_next = 1'b0;
                    REQ_STOP:
                    begin
                        play_next  = 1'b0;
                        frame_next = '0;
                        acc_next   = '0;
                    end
                    REQ_RESET:
                    begin
                        frame_next = '0;
                        acc_next   = '0;
                    end
                    REQ_SET:
                    begin
                        frame_next = set_frame;
                        acc_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            acc_reg   <= '0;
            play_reg  <= 1'b1;
        end
        else
        begin
            frame_reg <= frame_next;
            acc_reg   <= acc_next;
            play_reg  <= play_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        flags.tick_go  = (item_reg.req_type == REQ_TICK) && cfg.auto_play && play_reg
                         && (total > TOT_W'(1)) && (item_reg.delta_time != '0);
        flags.div_more = (cnt_reg != CNT_W'(DIV_N - 1));
        flags.q_zero   = (q_reg == '0);
        flags.no_stop  = cfg.looping || (q_reg < ACC_W'(steps));
        frame          = frame_reg;
        play           = play_reg;
    end

`ifndef NO_ASSERTIONS
    a_frame_in_sheet: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(frame_reg) < total_x)
        else $error("frame index beyond sheet");

    a_acc_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctl.op == OP_ADVANCE) |-> (acc_reg < ACC_W'(cfg.period)))
        else $error("accumulator holds a whole period after advance");
`endif

endmodule

`default_nettype wire
